// ===== src/spps_pkg.sv =====
// ----------------------------------------------------------------------------
// spps_pkg: shared types and constants for the sine PWM phase stepper
// Beat structs, sequencer states, divider handshake structs and the sine
// table that is built at elaboration.
// ----------------------------------------------------------------------------
package spps_pkg;

    // Block configuration
    localparam int TABLE_SIZE  = 360;
    localparam int BASIC_SPEED = 10;
    localparam int PWM_PERIOD  = 1000;

    localparam int SPEED_W    = 12;
    localparam int DUTY_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int NUM_PHASES = 3;
    localparam int PH_W       = 2;

    // Divider widths: dividend is a speed, BASIC_SPEED or a quotient; divisor is a speed, BASIC_SPEED or TABLE_SIZE
    localparam int TS_W  = $clog2(TABLE_SIZE + 1);
    localparam int DVD_W = SPEED_W;
    localparam int DVS_W = (TS_W > SPEED_W) ? TS_W : SPEED_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // Fixed-point constants for the table build
    localparam longint          Q30_ONE = 64'sd1073741824;
    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    // Input and result beats
    typedef struct packed {
        logic               direction;
        logic [SPEED_W-1:0] speed;
    } in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic              updated;
    } out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LIM,
        ST_DIV_QUO,
        ST_DIV_MOD,
        ST_COUNT,
        ST_ADDR,
        ST_LOAD,
        ST_OUT
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef logic [TABLE_SIZE-1:0][DUTY_W-1:0] rom_t;

    // Series term divided by its two factorial factors (k+1)*(k+2)
    function automatic longint unsigned fact_pair_div(longint unsigned term,
                                                      longint unsigned k);
        unique case (k)
            64'd0:   return term / 64'd2;
            64'd1:   return term / 64'd6;
            64'd2:   return term / 64'd12;
            64'd3:   return term / 64'd20;
            64'd4:   return term / 64'd30;
            64'd5:   return term / 64'd42;
            64'd6:   return term / 64'd56;
            64'd7:   return term / 64'd72;
            64'd8:   return term / 64'd90;
            64'd9:   return term / 64'd110;
            64'd10:  return term / 64'd132;
            64'd11:  return term / 64'd156;
            64'd12:  return term / 64'd182;
            64'd13:  return term / 64'd210;
            default: return term;
        endcase
    endfunction

    // Taylor series in Q30, sine (odd powers) or cosine (even powers)
    function automatic longint taylor_q30(longint unsigned x, bit start_sine);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned k;
        longint          sum;
        x2   = (x * x) >> 30;
        term = start_sine ? x : longint'(Q30_ONE);
        k    = start_sine ? 64'd1 : 64'd0;
        sum  = longint'(term);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = fact_pair_div(term, k);
            k    = k + 64'd2;
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    // Signed sine of 2*pi*m/TABLE_SIZE in Q30, exact at the 30-degree points
    function automatic longint sine_q30(int unsigned m);
        int unsigned     q;
        int unsigned     r;
        int unsigned     k;
        longint unsigned theta;
        longint          s;
        if (((12 * m) % TABLE_SIZE) == 0) begin
            k = (12 * m) / TABLE_SIZE;
            if (k == 0 || k == 6)  return 64'sd0;
            if (k == 3)            return Q30_ONE;
            if (k == 9)            return -Q30_ONE;
            if (k == 1 || k == 5)  return Q30_ONE / 2;
            if (k == 7 || k == 11) return -(Q30_ONE / 2);
        end
        q     = (4 * m) / TABLE_SIZE;
        r     = 4 * m - q * TABLE_SIZE;
        theta = (longint'(r) * PIH_Q30) / TABLE_SIZE;
        case (q & 3)
            0:       s = taylor_q30(theta, 1'b1);
            1:       s = taylor_q30(theta, 1'b0);
            2:       s = -taylor_q30(theta, 1'b1);
            default: s = -taylor_q30(theta, 1'b0);
        endcase
        if (s > Q30_ONE)  s = Q30_ONE;
        if (s < -Q30_ONE) s = -Q30_ONE;
        return s;
    endfunction

    // Duty table: sine shifted to [25, PWM_PERIOD-25]
    function automatic rom_t build_rom();
        rom_t            rom;
        int unsigned     m;
        longint unsigned shifted;
        longint unsigned v;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            m       = (i + 1) % TABLE_SIZE;
            shifted = longint'(sine_q30(m) + Q30_ONE);
            v       = (shifted * longint'(PWM_PERIOD - 50)) >> 31;
            rom[i]  = DUTY_W'(v + 64'd25);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

endpackage

// ===== src/spps_divider.sv =====
// ----------------------------------------------------------------------------
// spps_divider: iterative restoring divider
// One quotient bit per cycle; done pulses after the last quotient bit.
// ----------------------------------------------------------------------------
module spps_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  spps_pkg::div_req_t req,
    output spps_pkg::div_rsp_t rsp
);

    logic [spps_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [spps_pkg::DVD_W-1:0] qd_reg, qd_next;
    logic [spps_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [spps_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [spps_pkg::DVS_W:0]   trial;
    logic                       fits;

    // One shift-subtract step
    assign trial = {rem_reg, qd_reg[spps_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            qd_next   = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = spps_pkg::CNT_W'(spps_pkg::DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? spps_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[spps_pkg::DVS_W-1:0];
            qd_next  = {qd_reg[spps_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == spps_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = qd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/spps_sine_rom.sv =====
// ----------------------------------------------------------------------------
// spps_sine_rom: duty table with registered read
// One lookup per cycle from the elaboration-time sine table.
// ----------------------------------------------------------------------------
module spps_sine_rom (
    input  logic                        aclk,
    input  logic [spps_pkg::IDX_W-1:0]  addr,
    output logic [spps_pkg::DUTY_W-1:0] data_reg
);

    always_ff @(posedge aclk) begin
        data_reg <= spps_pkg::SINE_ROM[addr];
    end

endmodule

// ===== src/sine_pwm_phase_stepper.sv =====
// A zero-speed tick goes straight to the output stage, any other tick passes the
// wait count first; a reload adds address and load for each of the three phases,
// and a new speed adds a divide: one below the base speed, two at or above it.
// One tick at a time: the next beat is taken once the result is in the output
// register. Reset: sync active-low aresetn clears counters, last speed and stride,
// sets indices to 0, N/3, 2N/3 and loads duties.
// ----------------------------------------------------------------------------
// sine_pwm_phase_stepper: three-phase sine PWM duty sequencer
// Derives wait count and stride on a speed change with a shared divider,
// then steps three table indices and reloads the duties through one ROM port.
// ----------------------------------------------------------------------------
module sine_pwm_phase_stepper (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  spps_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output spps_pkg::out_t  m_data
);

    localparam logic [spps_pkg::IDX_W:0] TS_EXT = (spps_pkg::IDX_W + 1)'(spps_pkg::TABLE_SIZE);
    localparam logic [spps_pkg::IDX_W-1:0] IDX_B = spps_pkg::IDX_W'(spps_pkg::TABLE_SIZE / 3);
    localparam logic [spps_pkg::IDX_W-1:0] IDX_C =
        spps_pkg::IDX_W'(2 * (spps_pkg::TABLE_SIZE / 3));

    spps_pkg::state_t state_reg, state_next;

    logic                          dir_reg, dir_next;
    logic [spps_pkg::SPEED_W-1:0]  speed_reg, speed_next;
    logic [spps_pkg::SPEED_W-1:0]  last_speed_reg, last_speed_next;
    logic [spps_pkg::WAIT_W-1:0]   wait_limit_reg, wait_limit_next;
    logic [spps_pkg::WAIT_W-1:0]   wait_count_reg, wait_count_next;
    logic [spps_pkg::IDX_W-1:0]    stride_reg, stride_next;
    logic [spps_pkg::IDX_W-1:0]    phase_index_reg [spps_pkg::NUM_PHASES];
    logic [spps_pkg::IDX_W-1:0]    phase_index_next [spps_pkg::NUM_PHASES];
    logic [spps_pkg::DUTY_W-1:0]   held_reg [spps_pkg::NUM_PHASES];
    logic [spps_pkg::DUTY_W-1:0]   held_next [spps_pkg::NUM_PHASES];
    logic [spps_pkg::PH_W-1:0]     phase_reg, phase_next;
    logic                          upd_reg, upd_next;
    logic                          m_valid_reg, m_valid_next;
    spps_pkg::out_t                m_data_reg, m_data_next;

    spps_pkg::div_req_t            div_req;
    spps_pkg::div_rsp_t            div_rsp;
    logic [spps_pkg::IDX_W-1:0]    rom_addr;
    logic [spps_pkg::DUTY_W-1:0]   rom_data;

    logic                          tick_accept;
    logic                          out_free;
    logic                          slow;
    logic                          wait_more;
    logic                          last_phase;
    logic [spps_pkg::IDX_W-1:0]    cur_idx;
    logic [spps_pkg::IDX_W:0]      step_b;
    logic [spps_pkg::IDX_W:0]      step_sum;
    logic [spps_pkg::IDX_W-1:0]    step_idx;

    spps_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    spps_sine_rom u_rom (
        .aclk     (aclk),
        .addr     (rom_addr),
        .data_reg (rom_data)
    );

    assign tick_accept = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign slow        = (s_data.speed < spps_pkg::SPEED_W'(spps_pkg::BASIC_SPEED));
    assign wait_more   = (wait_count_reg < wait_limit_reg);
    assign last_phase  = (phase_reg == spps_pkg::PH_W'(spps_pkg::NUM_PHASES - 1));

    // Index stepper: add stride (or table size minus stride), wrap once
    assign cur_idx  = phase_index_reg[phase_reg];
    assign step_b   = dir_reg ? (TS_EXT - {1'b0, stride_reg}) : {1'b0, stride_reg};
    assign step_sum = {1'b0, cur_idx} + step_b;
    assign step_idx = (step_sum >= TS_EXT) ? spps_pkg::IDX_W'(step_sum - TS_EXT)
                                           : step_sum[spps_pkg::IDX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.speed == '0) begin
                        state_next = spps_pkg::ST_OUT;
                    end else if (s_data.speed != last_speed_reg) begin
                        state_next = slow ? spps_pkg::ST_DIV_LIM : spps_pkg::ST_DIV_QUO;
                    end else begin
                        state_next = spps_pkg::ST_COUNT;
                    end
                end
            end
            spps_pkg::ST_DIV_LIM: begin
                if (div_rsp.done) state_next = spps_pkg::ST_COUNT;
            end
            spps_pkg::ST_DIV_QUO: begin
                if (div_rsp.done) state_next = spps_pkg::ST_DIV_MOD;
            end
            spps_pkg::ST_DIV_MOD: begin
                if (div_rsp.done) state_next = spps_pkg::ST_COUNT;
            end
            spps_pkg::ST_COUNT: begin
                state_next = wait_more ? spps_pkg::ST_OUT : spps_pkg::ST_ADDR;
            end
            spps_pkg::ST_ADDR: begin
                state_next = spps_pkg::ST_LOAD;
            end
            spps_pkg::ST_LOAD: begin
                state_next = last_phase ? spps_pkg::ST_OUT : spps_pkg::ST_ADDR;
            end
            spps_pkg::ST_OUT: begin
                if (out_free) state_next = spps_pkg::ST_IDLE;
            end
            default: state_next = spps_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, divider requests, ROM address
    always_comb begin
        s_ready          = (state_reg == spps_pkg::ST_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = s_data.speed;
        div_req.divisor  = spps_pkg::DVS_W'(spps_pkg::BASIC_SPEED);
        rom_addr         = cur_idx;
        unique case (state_reg)
            spps_pkg::ST_IDLE: begin
                if (s_valid && s_data.speed != '0 && s_data.speed != last_speed_reg) begin
                    div_req.start = 1'b1;
                    if (slow) begin
                        div_req.dividend = spps_pkg::DVD_W'(spps_pkg::BASIC_SPEED);
                        div_req.divisor  = spps_pkg::DVS_W'(s_data.speed);
                    end
                end
            end
            spps_pkg::ST_DIV_QUO: begin
                // Reduce the stride modulo the table size
                div_req.start    = div_rsp.done;
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = spps_pkg::DVS_W'(spps_pkg::TABLE_SIZE);
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        dir_next        = dir_reg;
        speed_next      = speed_reg;
        last_speed_next = last_speed_reg;
        wait_limit_next = wait_limit_reg;
        wait_count_next = wait_count_reg;
        stride_next     = stride_reg;
        phase_index_next = phase_index_reg;
        held_next       = held_reg;
        phase_next      = phase_reg;
        upd_next        = upd_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        unique case (state_reg)
            spps_pkg::ST_IDLE: begin
                if (tick_accept) begin
                    dir_next   = s_data.direction;
                    speed_next = s_data.speed;
                    upd_next   = 1'b0;
                end
            end
            spps_pkg::ST_DIV_LIM: begin
                if (div_rsp.done) begin
                    wait_limit_next = spps_pkg::WAIT_W'(div_rsp.quotient) - 1'b1;
                    stride_next     = spps_pkg::IDX_W'(1);
                    last_speed_next = speed_reg;
                end
            end
            spps_pkg::ST_DIV_MOD: begin
                if (div_rsp.done) begin
                    wait_limit_next = '0;
                    stride_next     = div_rsp.remainder[spps_pkg::IDX_W-1:0];
                    last_speed_next = speed_reg;
                end
            end
            spps_pkg::ST_COUNT: begin
                if (wait_more) begin
                    wait_count_next = wait_count_reg + 1'b1;
                end else begin
                    wait_count_next = '0;
                    upd_next        = 1'b1;
                    phase_next      = '0;
                end
            end
            spps_pkg::ST_LOAD: begin
                held_next[phase_reg]        = rom_data;
                phase_index_next[phase_reg] = step_idx;
                // back to phase A after the last phase, keeps the index in range
                phase_next                  = last_phase ? '0 : phase_reg + 1'b1;
            end
            spps_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_data_next.duty_a  = held_reg[0];
                    m_data_next.duty_b  = held_reg[1];
                    m_data_next.duty_c  = held_reg[2];
                    m_data_next.updated = upd_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= spps_pkg::ST_IDLE;
            m_valid_reg        <= 1'b0;
            last_speed_reg     <= '0;
            wait_limit_reg     <= '0;
            wait_count_reg     <= '0;
            stride_reg         <= '0;
            phase_reg          <= '0;
            phase_index_reg[0] <= '0;
            phase_index_reg[1] <= IDX_B;
            phase_index_reg[2] <= IDX_C;
            held_reg[0]        <= spps_pkg::SINE_ROM[0];
            held_reg[1]        <= spps_pkg::SINE_ROM[IDX_B];
            held_reg[2]        <= spps_pkg::SINE_ROM[IDX_C];
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            last_speed_reg  <= last_speed_next;
            wait_limit_reg  <= wait_limit_next;
            wait_count_reg  <= wait_count_next;
            stride_reg      <= stride_next;
            phase_reg       <= phase_next;
            phase_index_reg <= phase_index_next;
            held_reg        <= held_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dir_reg    <= dir_next;
        speed_reg  <= speed_next;
        upd_reg    <= upd_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
